@@ sv/rvde_pkg.sv @@
`default_nettype none
package rvde_pkg;

  localparam int XLEN = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [6:0] {
    OPC_OP     = 7'h33,
    OPC_OPIMM  = 7'h13,
    OPC_LOAD   = 7'h03,
    OPC_STORE  = 7'h23,
    OPC_JAL    = 7'h6f,
    OPC_JALR   = 7'h67,
    OPC_BRANCH = 7'h63,
    OPC_LUI    = 7'h37,
    OPC_AUIPC  = 7'h17
  } opcode_t;

  localparam logic [6:0] FUNCT7_ALT = 7'b0100000;

  typedef enum logic [3:0] {
    CLS_OP, CLS_OPIMM, CLS_LOAD, CLS_STORE, CLS_JAL, CLS_JALR,
    CLS_BRANCH, CLS_LUI, CLS_AUIPC, CLS_FORMAT, CLS_ILLEGAL
  } class_t;

  typedef struct packed {
    logic [0:0]  action;
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
    logic [31:0] load_bytes;
  } in_word_t;

  typedef struct packed {
    logic [0:0]  rd_write;
    logic [4:0]  rd_index;
    logic [31:0] rd_value;
    logic [31:0] next_pc;
    logic [0:0]  mem_read;
    logic [0:0]  mem_write;
    logic [31:0] mem_address;
    logic [1:0]  mem_size;
    logic [31:0] store_data;
    logic [0:0]  illegal;
  } out_word_t;

  // decoded word handed from front to back
  typedef struct packed {
    class_t      cls;
    logic [2:0]  funct3;
    logic        alt;
    logic [4:0]  rd;
    logic [1:0]  size;
    logic [31:0] imm;
    logic [31:0] pc;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
    logic [31:0] load_bytes;
  } dec_word_t;

endpackage
`default_nettype wire

@@ sv/rvde_if.sv @@
`default_nettype none
interface rvde_in_if;
  logic valid;
  logic ready;
  rvde_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rvde_out_if;
  logic valid;
  logic ready;
  rvde_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/rvde_front.sv @@
`default_nettype none
module rvde_front (
  input  wire logic                clk,
  input  wire logic                rst,
  rvde_in_if.sink                  in_ch,
  output rvde_pkg::dec_word_t      dec,
  output logic                     dec_valid,
  input  wire logic                dec_ready
);

  logic [31:0] ins;
  rvde_pkg::dec_word_t d;
  logic [2:0] f3;

  assign ins = in_ch.data.instruction;
  assign f3 = ins[14:12];
  assign in_ch.ready = !dec_valid || dec_ready;

  always_comb begin
    d = '0;
    d.funct3 = f3;
    d.alt = (ins[31:25] == rvde_pkg::FUNCT7_ALT);
    d.rd = ins[11:7];
    d.size = (f3[1:0] == 2'd3) ? 2'd2 : f3[1:0];
    d.pc = in_ch.data.pc;
    d.rs1_value = in_ch.data.rs1_value;
    d.rs2_value = in_ch.data.rs2_value;
    d.load_bytes = in_ch.data.load_bytes;
    d.imm = {{20{ins[31]}}, ins[31:20]};
    if (in_ch.data.action == 1'b1) begin
      d.cls = rvde_pkg::CLS_FORMAT;
    end else begin
      unique case (ins[6:0])
        rvde_pkg::OPC_OP: d.cls = rvde_pkg::CLS_OP;
        rvde_pkg::OPC_OPIMM: begin
          d.cls = rvde_pkg::CLS_OPIMM;
          if (f3 == 3'd1 || f3 == 3'd5) d.imm = {27'd0, ins[24:20]};
        end
        rvde_pkg::OPC_LOAD: d.cls = rvde_pkg::CLS_LOAD;
        rvde_pkg::OPC_STORE: begin
          d.cls = rvde_pkg::CLS_STORE;
          d.imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        end
        rvde_pkg::OPC_JAL: begin
          d.cls = rvde_pkg::CLS_JAL;
          d.imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        end
        rvde_pkg::OPC_JALR: d.cls = rvde_pkg::CLS_JALR;
        rvde_pkg::OPC_BRANCH: begin
          d.cls = rvde_pkg::CLS_BRANCH;
          d.imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        end
        rvde_pkg::OPC_LUI: begin
          d.cls = rvde_pkg::CLS_LUI;
          d.imm = {ins[31:12], 12'd0};
        end
        rvde_pkg::OPC_AUIPC: begin
          d.cls = rvde_pkg::CLS_AUIPC;
          d.imm = {ins[31:12], 12'd0};
        end
        default: d.cls = rvde_pkg::CLS_ILLEGAL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (in_ch.ready) begin
      dec_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) dec <= d;
  end

endmodule
`default_nettype wire

@@ sv/rvde_queue.sv @@
`default_nettype none
module rvde_queue #(
  parameter int DEPTH = rvde_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rvde_pkg::dec_word_t wr_data,
  input  wire logic                wr_valid,
  output logic                     wr_ready,
  output rvde_pkg::dec_word_t      rd_data,
  output logic                     rd_valid,
  input  wire logic                rd_ready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rvde_pkg::dec_word_t slots [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic push, pop;

  // full blocks the writer outright so the read side never reaches the write side
  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data = slots[rptr];
  assign pop = rd_valid && rd_ready;
  assign push = wr_valid && wr_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (pop) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wr_data;
  end

  no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue overflow");
  pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty queue");
  count_tracks: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1) else $error("count slip");

endmodule
`default_nettype wire

@@ sv/rvde_back.sv @@
`default_nettype none
module rvde_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rvde_pkg::dec_word_t dec,
  input  wire logic                dec_valid,
  output logic                     dec_ready,
  rvde_out_if.source               out_ch
);

  rvde_pkg::out_word_t r;
  logic [31:0] a, b, opb, pc4, sum, tgt;
  logic lts, ltu, taken;

  assign a = dec.rs1_value;
  assign b = dec.rs2_value;
  assign pc4 = dec.pc + 32'd4;
  assign dec_ready = !out_ch.valid || out_ch.ready;
  assign lts = $signed(a) < $signed(opb);
  assign ltu = a < opb;
  assign sum = a + dec.imm;
  assign tgt = dec.pc + dec.imm;

  always_comb begin
    opb = (dec.cls == rvde_pkg::CLS_OP || dec.cls == rvde_pkg::CLS_BRANCH) ? b : dec.imm;
  end

  function automatic logic [31:0] alu(input logic [2:0] f3, input logic sub,
      input logic alt, input logic [31:0] x, input logic [31:0] y,
      input logic lt_s, input logic lt_u);
    logic [31:0] res;
    res = '0;
    case (f3)
      3'd0: res = sub ? x - y : x + y;
      3'd1: res = x << y[4:0];
      3'd2: res = {31'd0, lt_s};
      3'd3: res = {31'd0, lt_u};
      3'd4: res = x ^ y;
      3'd5: res = alt ? 32'($signed(x) >>> y[4:0]) : x >> y[4:0];
      3'd6: res = x | y;
      default: res = x & y;
    endcase
    return res;
  endfunction

  always_comb begin
    r = '0;
    r.next_pc = pc4;
    taken = 1'b0;
    unique case (dec.cls)
      rvde_pkg::CLS_FORMAT: begin
        r.rd_write = 1'b1;
        r.rd_index = dec.rd;
        case (dec.size)
          2'd0: r.rd_value = dec.funct3[2] ? {24'd0, dec.load_bytes[7:0]}
                           : {{24{dec.load_bytes[7]}}, dec.load_bytes[7:0]};
          2'd1: r.rd_value = dec.funct3[2] ? {16'd0, dec.load_bytes[15:0]}
                           : {{16{dec.load_bytes[15]}}, dec.load_bytes[15:0]};
          default: r.rd_value = dec.load_bytes;
        endcase
      end
      rvde_pkg::CLS_OP, rvde_pkg::CLS_OPIMM: begin
        r.rd_write = 1'b1;
        r.rd_index = dec.rd;
        r.rd_value = alu(dec.funct3, dec.cls == rvde_pkg::CLS_OP && dec.alt,
                         dec.alt, a, opb, lts, ltu);
      end
      rvde_pkg::CLS_LOAD: begin
        r.rd_index = dec.rd;
        r.mem_read = 1'b1;
        r.mem_address = sum;
        r.mem_size = dec.size;
      end
      rvde_pkg::CLS_STORE: begin
        r.mem_write = 1'b1;
        r.mem_address = sum;
        r.mem_size = dec.size;
        r.store_data = b;
      end
      rvde_pkg::CLS_JAL: begin
        r.rd_write = 1'b1;
        r.rd_index = dec.rd;
        r.rd_value = pc4;
        r.next_pc = tgt;
      end
      rvde_pkg::CLS_JALR: begin
        r.rd_write = 1'b1;
        r.rd_index = dec.rd;
        r.rd_value = pc4;
        r.next_pc = {sum[31:1], 1'b0};
      end
      rvde_pkg::CLS_BRANCH: begin
        case (dec.funct3)
          3'd0: taken = (a == b);
          3'd1: taken = (a != b);
          3'd4: taken = lts;
          3'd5: taken = !lts;
          3'd6: taken = ltu;
          3'd7: taken = !ltu;
          default: taken = 1'b0;
        endcase
        if (taken) r.next_pc = tgt;
      end
      rvde_pkg::CLS_LUI: begin
        r.rd_write = 1'b1;
        r.rd_index = dec.rd;
        r.rd_value = dec.imm;
      end
      rvde_pkg::CLS_AUIPC: begin
        r.rd_write = 1'b1;
        r.rd_index = dec.rd;
        r.rd_value = tgt;
      end
      default: r.illegal = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (dec_ready) begin
      out_ch.valid <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid && dec_ready) out_ch.data <= r;
  end

endmodule
`default_nettype wire

@@ sv/rv32i_decode_execute.sv @@
// Path: an accepted input word is held in turn in the decode register, a queue slot
//   and the result register before its result word leaves.
// Throughput: one word per cycle while the output is not held back; every operation is combinational work.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
// Payload registers carry no reset.
`default_nettype none
module rv32i_decode_execute #(
  parameter int QUEUE_DEPTH = rvde_pkg::QUEUE_DEPTH
) (
  input wire logic   clk,
  input wire logic   rst,
  rvde_in_if.sink    in_ch,
  rvde_out_if.source out_ch
);

  // front: classify the word and build immediates
  rvde_pkg::dec_word_t f_word, q_word;
  logic f_valid, f_ready, q_valid, q_ready;

  rvde_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .dec(f_word), .dec_valid(f_valid), .dec_ready(f_ready)
  );

  // queue: decouple decode from execute so each side stalls on its own
  rvde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .wr_data(f_word), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_word), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  // back: ALU, branch compare, address add, load format; hold result until taken
  rvde_back u_back (
    .clk(clk), .rst(rst),
    .dec(q_word), .dec_valid(q_valid), .dec_ready(q_ready), .out_ch(out_ch)
  );

endmodule
`default_nettype wire
